[rtl/core/taf_pkg.sv]
`default_nettype none

package taf_pkg;

  // default widths of coordinates and contact ids
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 8;

  // normalized output: fraction bits of the scaled position
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned OUT_BITS  = 16;

  // job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  // default area after reset
  localparam int AREA_MIN_RESET = 0;
  localparam int AREA_MAX_RESET = 4095;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_CONTACT    = 2'd0,
    CMD_ABS_TOGGLE = 2'd1,
    CMD_CAL_TOGGLE = 2'd2
  } cmd_e;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_AREA_LEFT   = 2'd0,
    REG_AREA_TOP    = 2'd1,
    REG_AREA_RIGHT  = 2'd2,
    REG_AREA_BOTTOM = 2'd3
  } reg_idx_e;

  // back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_DIV,
    BK_AXIS,
    BK_DONE
  } back_state_e;

  // queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

[rtl/core/taf_queue.sv]
`default_nettype none

module taf_queue
  import taf_pkg::*;
#(
  parameter int unsigned WIDTH = 6 * COORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output queue_status_t         status_o
);

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;

  // pointer wrap helper
  function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
    logic [PTR_BITS-1:0] r;
    if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_BITS'(1);
    end
    return r;
  endfunction

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ptr_next(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_next(rd_ptr_q);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

[rtl/core/taf_front.sv]
`default_nettype none

module taf_front
  import taf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = ID_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // accepted item
  input  wire logic                          accept_i,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic [ID_BITS-1:0]            contact_id_i,
  input  wire logic                          tip_i,
  input  wire logic signed [COORD_BITS-1:0]  contact_x_i,
  input  wire logic signed [COORD_BITS-1:0]  contact_y_i,
  input  wire logic                          last_i,
  // default area from configuration
  input  wire logic signed [COORD_BITS-1:0]  area_left_i,
  input  wire logic signed [COORD_BITS-1:0]  area_top_i,
  input  wire logic signed [COORD_BITS-1:0]  area_right_i,
  input  wire logic signed [COORD_BITS-1:0]  area_bottom_i,
  // job toward the back end: px, py, left, top, right, bottom from the lowest bit up
  output logic                               push_o,
  output logic [6*COORD_BITS-1:0]            job_o
);

  localparam int unsigned C = COORD_BITS;

  // modes and calibration
  logic                absolute_on_q, absolute_on_d;
  logic                calibrating_q, calibrating_d;
  logic                cal_valid_q, cal_valid_d;
  logic signed [C-1:0] cal_l_q, cal_t_q, cal_r_q, cal_b_q;
  logic signed [C-1:0] cal_l_d, cal_t_d, cal_r_d, cal_b_d;
  logic                box_valid_q, box_valid_d;
  logic signed [C-1:0] box_l_q, box_t_q, box_r_q, box_b_q;
  logic signed [C-1:0] box_l_d, box_t_d, box_r_d, box_b_d;
  // event collection
  logic [ID_BITS-1:0]  primary_id_q, primary_id_d;
  logic                first_seen_q, first_seen_d;
  logic [ID_BITS-1:0]  first_id_q, first_id_d;
  logic signed [C-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic                match_seen_q, match_seen_d;
  logic signed [C-1:0] match_x_q, match_x_d, match_y_q, match_y_d;

  logic signed [C-1:0] px, py, rl, rt, rr, rb;

  // item decode and state update
  always_comb begin
    absolute_on_d = absolute_on_q;
    calibrating_d = calibrating_q;
    cal_valid_d   = cal_valid_q;
    cal_l_d = cal_l_q; cal_t_d = cal_t_q; cal_r_d = cal_r_q; cal_b_d = cal_b_q;
    box_valid_d   = box_valid_q;
    box_l_d = box_l_q; box_t_d = box_t_q; box_r_d = box_r_q; box_b_d = box_b_q;
    primary_id_d  = primary_id_q;
    first_seen_d  = first_seen_q;
    first_id_d    = first_id_q;
    first_x_d     = first_x_q;
    first_y_d     = first_y_q;
    match_seen_d  = match_seen_q;
    match_x_d     = match_x_q;
    match_y_d     = match_y_q;
    push_o        = 1'b0;
    px = '0; py = '0;

    if (accept_i) begin
      unique case (cmd_e'(cmd_i))
        CMD_ABS_TOGGLE: begin
          absolute_on_d = !absolute_on_q;
          first_seen_d  = 1'b0;
          match_seen_d  = 1'b0;
        end
        CMD_CAL_TOGGLE: begin
          // leaving calibration commits the box if one was grown
          if (calibrating_q && box_valid_q) begin
            cal_l_d = box_l_q; cal_t_d = box_t_q; cal_r_d = box_r_q; cal_b_d = box_b_q;
            cal_valid_d = 1'b1;
          end
          if (calibrating_q) begin
            box_valid_d = 1'b0;
          end
          calibrating_d = !calibrating_q;
          first_seen_d  = 1'b0;
          match_seen_d  = 1'b0;
        end
        CMD_CONTACT: begin
          if (tip_i && calibrating_q) begin
            // grow the bounding box
            if (!box_valid_q) begin
              box_l_d = contact_x_i; box_t_d = contact_y_i;
              box_r_d = contact_x_i; box_b_d = contact_y_i;
              box_valid_d = 1'b1;
            end else begin
              if (contact_x_i < box_l_q) box_l_d = contact_x_i;
              if (contact_y_i < box_t_q) box_t_d = contact_y_i;
              if (contact_x_i > box_r_q) box_r_d = contact_x_i;
              if (contact_y_i > box_b_q) box_b_d = contact_y_i;
            end
          end else if (tip_i && absolute_on_q) begin
            // remember first contact and the one matching the primary id
            if (!first_seen_q) begin
              first_id_d   = contact_id_i;
              first_x_d    = contact_x_i;
              first_y_d    = contact_y_i;
              first_seen_d = 1'b1;
            end
            if (!match_seen_q && (contact_id_i == primary_id_q)) begin
              match_x_d    = contact_x_i;
              match_y_d    = contact_y_i;
              match_seen_d = 1'b1;
            end
          end

          // event end
          if (last_i) begin
            if (!calibrating_q && absolute_on_q && first_seen_d) begin
              push_o = 1'b1;
              if (match_seen_d) begin
                px = match_x_d;
                py = match_y_d;
              end else begin
                primary_id_d = first_id_d;
                px = first_x_d;
                py = first_y_d;
              end
            end
            first_seen_d = 1'b0;
            match_seen_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // active area selection
  assign rl = cal_valid_q ? cal_l_q : area_left_i;
  assign rt = cal_valid_q ? cal_t_q : area_top_i;
  assign rr = cal_valid_q ? cal_r_q : area_right_i;
  assign rb = cal_valid_q ? cal_b_q : area_bottom_i;

  assign job_o = {rb, rr, rt, rl, py, px};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absolute_on_q <= 1'b0;
      calibrating_q <= 1'b0;
      cal_valid_q   <= 1'b0;
      box_valid_q   <= 1'b0;
      first_seen_q  <= 1'b0;
      match_seen_q  <= 1'b0;
      primary_id_q  <= '0;
      cal_l_q <= '0; cal_t_q <= '0; cal_r_q <= '0; cal_b_q <= '0;
    end else begin
      absolute_on_q <= absolute_on_d;
      calibrating_q <= calibrating_d;
      cal_valid_q   <= cal_valid_d;
      box_valid_q   <= box_valid_d;
      first_seen_q  <= first_seen_d;
      match_seen_q  <= match_seen_d;
      primary_id_q  <= primary_id_d;
      cal_l_q <= cal_l_d; cal_t_q <= cal_t_d; cal_r_q <= cal_r_d; cal_b_q <= cal_b_d;
    end
  end

  // payload held under valid flags
  always_ff @(posedge clk_i) begin
    box_l_q   <= box_l_d;
    box_t_q   <= box_t_d;
    box_r_q   <= box_r_d;
    box_b_q   <= box_b_d;
    first_id_q <= first_id_d;
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    match_x_q <= match_x_d;
    match_y_q <= match_y_d;
  end

endmodule

`default_nettype wire

[rtl/core/taf_back.sv]
`default_nettype none

module taf_back
  import taf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // job queue side
  input  wire queue_status_t             queue_status_i,
  input  wire logic [6*COORD_BITS-1:0]   job_i,
  output logic                           pop_o,
  // result side: screen_x, screen_y from the lowest bit up
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [2*OUT_BITS-1:0]          out_data_o
);

  localparam int unsigned C        = COORD_BITS;
  localparam int unsigned CNT_BITS = $clog2(FRAC_BITS);

  back_state_e state_q, state_d;
  logic                  axis_q, axis_d;
  logic [6*C-1:0]        job_q;
  logic [C:0]            rem_q, rem_d;
  logic [C:0]            div_q, div_d;
  logic [FRAC_BITS-1:0]  quot_q, quot_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [OUT_BITS-1:0]   sx_q, sx_d;
  logic                  out_valid_q, out_valid_d;
  logic [2*OUT_BITS-1:0] out_data_q, out_data_d;
  logic                  load_job;

  // clamp and span for the current axis
  logic signed [C-1:0]   p_sel, lo_sel, hi_sel;
  logic signed [C+1:0]   p_w, lo_w, hi_w, clamp_w, span_w, diff_w;
  logic                  span_pos;
  // one restoring division step
  logic [C+1:0]          trial;
  logic                  take;

  always_comb begin
    if (axis_q) begin
      p_sel  = job_q[1*C +: C];
      lo_sel = job_q[3*C +: C];
      hi_sel = job_q[5*C +: C];
    end else begin
      p_sel  = job_q[0*C +: C];
      lo_sel = job_q[2*C +: C];
      hi_sel = job_q[4*C +: C];
    end
    p_w  = (C+2)'(p_sel);
    lo_w = (C+2)'(lo_sel);
    hi_w = (C+2)'(hi_sel);
    clamp_w = (p_w > hi_w) ? hi_w : p_w;
    if (clamp_w < lo_w) begin
      clamp_w = lo_w;
    end
    span_w   = hi_w - lo_w + (C+2)'(1);
    diff_w   = clamp_w - lo_w;
    span_pos = !span_w[C+1] && (span_w != '0);
  end

  assign trial = {rem_q, 1'b0};
  assign take  = (trial >= {1'b0, div_q});

  // sequencer: per axis a setup, FRAC_BITS division steps if the span is positive, and a wrap-up
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    rem_d       = rem_q;
    div_d       = div_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    sx_d        = sx_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    load_job    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      BK_IDLE: begin
        if (!queue_status_i.empty) begin
          pop_o    = 1'b1;
          load_job = 1'b1;
          axis_d   = 1'b0;
          state_d  = BK_PREP;
        end
      end
      BK_PREP: begin
        if (span_pos) begin
          rem_d   = diff_w[C:0];
          div_d   = span_w[C:0];
          quot_d  = '0;
          cnt_d   = CNT_BITS'(FRAC_BITS - 1);
          state_d = BK_DIV;
        end else begin
          quot_d  = '0;
          state_d = BK_AXIS;
        end
      end
      BK_DIV: begin
        rem_d  = take ? (C+1)'(trial - {1'b0, div_q}) : trial[C:0];
        quot_d = {quot_q[FRAC_BITS-2:0], take};
        cnt_d  = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = BK_AXIS;
        end
      end
      BK_AXIS: begin
        if (!axis_q) begin
          sx_d    = quot_q[OUT_BITS-1:0];
          axis_d  = 1'b1;
          state_d = BK_PREP;
        end else begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {quot_q[OUT_BITS-1:0], sx_q};
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (load_job) begin
      job_q <= job_i;
    end
    rem_q      <= rem_d;
    div_q      <= div_d;
    quot_q     <= quot_d;
    sx_q       <= sx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (div_q != '0))
    else $error("divisor zero during division");

  // partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < div_q))
    else $error("remainder not below divisor");

  // a job is taken only when idle and one is queued
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ((state_q == BK_IDLE) && !queue_status_i.empty))
    else $error("job taken while busy or queue empty");

  // the output register is only loaded when free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

[rtl/core/touch_contact_to_absolute_pointer_core.sv]
// Touchpad contact to absolute pointer core.
// Input stream: one transfer per contact or command. tuser carries the command
// (contact, toggle absolute mode, toggle calibration mode), tlast closes a report
// event, tdata carries contact id, tip, x and y. Command transfers and contacts
// that end no event produce nothing.
// Output stream: one transfer per event that ends with a chosen contact in
// absolute mode outside calibration, holding the scaled x and y in 0..65535.
// Configuration: APB registers for the default area, at byte addresses 0, 4, 8, 12
// (left, top, right, bottom); pready is always high, reads return the register.
// The front end handles each input transfer as it is accepted. A result job goes
// through a two-entry queue to the back end, whose shared serial divider runs
// a setup step, 16 division steps and a wrap-up step per axis, skipping the
// division steps for an axis whose area span is empty. The back end takes a new
// job only when idle, after the last result went into the output register;
// contacts that end no event are taken every cycle while the queue has room.
// When the output receiver stalls the result waits in the output register, the
// back end finishes one more job, then the queue fills and s_axis_tready drops.
// Reset clears both modes, calibration state, primary id and any pending result.
`default_nettype none

module touch_contact_to_absolute_pointer_core
  import taf_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned ID_BITS    = ID_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // contact_id, tip, contact_x, contact_y from the lowest bit up, zero padded
  input  wire logic [((ID_BITS+1+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]               s_axis_tuser,
  input  wire logic                     s_axis_tlast,
  // output stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // screen_x, screen_y from the lowest bit up
  output logic [2*OUT_BITS-1:0]         m_axis_tdata,
  // configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  localparam int unsigned C = COORD_BITS;

  logic signed [C-1:0] area_left_q, area_top_q, area_right_q, area_bottom_q;
  logic                cfg_write;
  reg_idx_e            cfg_idx;

  logic                accept;
  logic                push;
  logic [6*C-1:0]      push_job;
  logic [6*C-1:0]      pop_job;
  logic                pop;
  queue_status_t       queue_status;

  // register file write
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_left_q   <= C'(AREA_MIN_RESET);
      area_top_q    <= C'(AREA_MIN_RESET);
      area_right_q  <= C'(AREA_MAX_RESET);
      area_bottom_q <= C'(AREA_MAX_RESET);
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_AREA_LEFT:   area_left_q   <= pwdata[C-1:0];
        REG_AREA_TOP:    area_top_q    <= pwdata[C-1:0];
        REG_AREA_RIGHT:  area_right_q  <= pwdata[C-1:0];
        REG_AREA_BOTTOM: area_bottom_q <= pwdata[C-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read, sign extended
  always_comb begin
    unique case (cfg_idx)
      REG_AREA_LEFT:   prdata = APB_DATA_BITS'(area_left_q);
      REG_AREA_TOP:    prdata = APB_DATA_BITS'(area_top_q);
      REG_AREA_RIGHT:  prdata = APB_DATA_BITS'(area_right_q);
      REG_AREA_BOTTOM: prdata = APB_DATA_BITS'(area_bottom_q);
      default:         prdata = '0;
    endcase
  end

  // input transfer
  assign s_axis_tready = !queue_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  taf_front #(
    .COORD_BITS (COORD_BITS),
    .ID_BITS    (ID_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .cmd_i         (s_axis_tuser),
    .contact_id_i  (s_axis_tdata[ID_BITS-1:0]),
    .tip_i         (s_axis_tdata[ID_BITS]),
    .contact_x_i   (s_axis_tdata[ID_BITS+1 +: C]),
    .contact_y_i   (s_axis_tdata[ID_BITS+1+C +: C]),
    .last_i        (s_axis_tlast),
    .area_left_i   (area_left_q),
    .area_top_i    (area_top_q),
    .area_right_i  (area_right_q),
    .area_bottom_i (area_bottom_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  taf_queue #(
    .WIDTH (6 * C)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (queue_status)
  );

  taf_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (queue_status),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata)
  );

endmodule

`default_nettype wire

[bench/touch_contact_to_absolute_pointer_core_tb.sv]
module touch_contact_to_absolute_pointer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import taf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS = 340;

  // one input transfer: command plus contact fields
  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         id;
    logic               tip;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } contact_item_t;

  // how a directed row gets its expected pointer
  typedef enum logic [1:0] {
    OUT_PREDICTED,
    OUT_NONE,
    OUT_GIVEN
  } out_kind_e;

  typedef struct packed {
    contact_item_t item;
    out_kind_e     kind;
    logic [15:0]   ex;
    logic [15:0]   ey;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // contact_id, tip, contact_x, contact_y from the lowest bit up, zero padded
  logic [47:0] s_axis_tdata = '0;
  // cmd
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // screen_x, screen_y from the lowest bit up
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic        pready;

  touch_contact_to_absolute_pointer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // pointer tracking state, mirrors the block
  logic signed [15:0] area_cfg [4];
  logic signed [15:0] cal_area [4];
  logic signed [15:0] box [4];
  bit                 abs_mode, cal_mode, cal_area_ok, box_ok;
  logic [7:0]         lead_id;
  bit                 first_ok, match_ok;
  logic [7:0]         first_id;
  logic signed [15:0] first_x, first_y, match_x, match_y;

  logic [31:0] pointer_q [$];   // {screen_y, screen_x}
  dir_row_t    dir_rows [$];
  int          err_cnt = 0;
  int          sent_cnt = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  bit          cal_tips_ok = 1'b0;

  // clamp into lo..hi and scale to 0..65535
  function automatic logic [15:0] normalize_axis(logic signed [15:0] lo,
                                                 logic signed [15:0] hi,
                                                 logic signed [15:0] p);
    longint c, span, q;
    c = p;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    span = longint'(hi) + 1 - longint'(lo);
    if (span <= 0) return '0;
    q = ((c - lo) * 65536) / span;
    return q[15:0];
  endfunction

  // update tracking state for one accepted transfer
  task automatic advance_pointer(input contact_item_t it, output bit fired,
                                 output logic [15:0] sx, output logic [15:0] sy);
    logic signed [15:0] px, py;
    fired = 1'b0;
    sx = '0;
    sy = '0;
    if (it.cmd == CMD_ABS_TOGGLE) begin
      abs_mode = !abs_mode;
      first_ok = 1'b0;
      match_ok = 1'b0;
      return;
    end
    if (it.cmd == CMD_CAL_TOGGLE) begin
      if (cal_mode && box_ok) begin
        cal_area = box;
        cal_area_ok = 1'b1;
      end
      if (cal_mode) box_ok = 1'b0;
      cal_mode = !cal_mode;
      first_ok = 1'b0;
      match_ok = 1'b0;
      return;
    end
    if (it.cmd != CMD_CONTACT) return;

    // grow the calibration box or collect the event's candidates
    if (it.tip && cal_mode) begin
      if (!box_ok) begin
        box[REG_AREA_LEFT] = it.x;
        box[REG_AREA_TOP] = it.y;
        box[REG_AREA_RIGHT] = it.x;
        box[REG_AREA_BOTTOM] = it.y;
        box_ok = 1'b1;
      end else begin
        if (it.x < box[REG_AREA_LEFT]) box[REG_AREA_LEFT] = it.x;
        if (it.y < box[REG_AREA_TOP]) box[REG_AREA_TOP] = it.y;
        if (it.x > box[REG_AREA_RIGHT]) box[REG_AREA_RIGHT] = it.x;
        if (it.y > box[REG_AREA_BOTTOM]) box[REG_AREA_BOTTOM] = it.y;
      end
    end else if (it.tip && abs_mode) begin
      if (!first_ok) begin
        first_id = it.id;
        first_x = it.x;
        first_y = it.y;
        first_ok = 1'b1;
      end
      if (!match_ok && it.id == lead_id) begin
        match_x = it.x;
        match_y = it.y;
        match_ok = 1'b1;
      end
    end

    if (!it.last) return;
    if (cal_mode || !abs_mode || !first_ok) begin
      first_ok = 1'b0;
      match_ok = 1'b0;
      return;
    end
    if (match_ok) begin
      px = match_x;
      py = match_y;
    end else begin
      lead_id = first_id;
      px = first_x;
      py = first_y;
    end
    first_ok = 1'b0;
    match_ok = 1'b0;
    fired = 1'b1;
    if (cal_area_ok) begin
      sx = normalize_axis(cal_area[REG_AREA_LEFT], cal_area[REG_AREA_RIGHT], px);
      sy = normalize_axis(cal_area[REG_AREA_TOP], cal_area[REG_AREA_BOTTOM], py);
    end else begin
      sx = normalize_axis(area_cfg[REG_AREA_LEFT], area_cfg[REG_AREA_RIGHT], px);
      sy = normalize_axis(area_cfg[REG_AREA_TOP], area_cfg[REG_AREA_BOTTOM], py);
    end
  endtask

  // drive one input transfer, wait for it, then record what it should produce
  task automatic push_item(input contact_item_t it, input out_kind_e kind,
                           input logic [15:0] ex, input logic [15:0] ey);
    bit          fired;
    logic [15:0] sx, sy;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, it.y, it.x, it.tip, it.id};
    s_axis_tuser <= it.cmd;
    s_axis_tlast <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_pointer(it, fired, sx, sy);
    if (it.cmd != CMD_UNUSED) sent_cnt++;
    case (kind)
      OUT_PREDICTED: if (fired) pointer_q.insert(pointer_q.size(), {sy, sx});
      OUT_GIVEN:     pointer_q.insert(pointer_q.size(), {ey, ex});
      default:       ;
    endcase
  endtask

  task automatic add_row(logic [1:0] cmd, logic [7:0] id, logic tip, int x, int y,
                         logic last, out_kind_e kind, logic [15:0] ex, logic [15:0] ey);
    dir_row_t r;
    r.item.cmd = cmd;
    r.item.id = id;
    r.item.tip = tip;
    r.item.x = x[15:0];
    r.item.y = y[15:0];
    r.item.last = last;
    r.kind = kind;
    r.ex = ex;
    r.ey = ey;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // register write then read back over the configuration port
  task automatic write_area(input reg_idx_e idx, input logic signed [15:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{val[15]}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    area_cfg[idx] = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[15:0] !== val) begin
      $error("area register %s: expected %0d, actual %0d", idx.name(), val,
             $signed(rd[15:0]));
      err_cnt++;
    end
  endtask

  task automatic set_area(int l, int t, int r, int b);
    write_area(REG_AREA_LEFT, l[15:0]);
    write_area(REG_AREA_TOP, t[15:0]);
    write_area(REG_AREA_RIGHT, r[15:0]);
    write_area(REG_AREA_BOTTOM, b[15:0]);
  endtask

  // stop sending, then wait until every pointer has come out and the back end is quiet
  task automatic wait_quiet(int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pointer_q.size() != 0) @(posedge clk_i);
    repeat (cycles) @(posedge clk_i);
  endtask

  // coordinate mostly near the active area, sometimes anywhere
  function automatic logic signed [15:0] pick_coord(longint lo, longint hi);
    longint v;
    if ($urandom_range(0, 3) == 0 || hi < lo) return 16'($urandom);
    v = lo - 24 + longint'($urandom_range(0, 32'(hi - lo + 48)));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [7:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return lead_id;
    if (r < 8) return 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  // n contacts, closed by the last flag when close is set
  task automatic send_contacts(int n, bit tips_ok, bit close);
    contact_item_t it;
    bit            use_cal;
    for (int i = 0; i < n; i++) begin
      use_cal = cal_area_ok;
      it.cmd = CMD_CONTACT;
      it.id = pick_id();
      it.tip = tips_ok ? ($urandom_range(0, 9) != 0) : 1'b0;
      it.x = use_cal ? pick_coord(cal_area[REG_AREA_LEFT], cal_area[REG_AREA_RIGHT])
                     : pick_coord(area_cfg[REG_AREA_LEFT], area_cfg[REG_AREA_RIGHT]);
      it.y = use_cal ? pick_coord(cal_area[REG_AREA_TOP], cal_area[REG_AREA_BOTTOM])
                     : pick_coord(area_cfg[REG_AREA_TOP], area_cfg[REG_AREA_BOTTOM]);
      it.last = close && (i == n - 1);
      push_item(it, OUT_PREDICTED, '0, '0);
    end
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    contact_item_t it;
    it = contact_item_t'($urandom);
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.cmd = cmd;
    push_item(it, OUT_PREDICTED, '0, '0);
  endtask

  // random traffic: mostly well formed events, some toggles, noise and cut events
  task automatic run_random(int goal);
    int r;
    while (sent_cnt < goal) begin
      r = $urandom_range(0, 99);
      if (!abs_mode && r < 60) begin
        send_cmd(CMD_ABS_TOGGLE);
      end else if (r < 3) begin
        send_cmd(CMD_ABS_TOGGLE);
      end else if (r < 7) begin
        send_cmd(CMD_CAL_TOGGLE);
        repeat ($urandom_range(1, 3)) send_contacts($urandom_range(1, 3), cal_tips_ok, 1'b1);
        send_cmd(CMD_CAL_TOGGLE);
      end else if (r < 9) begin
        send_cmd(CMD_UNUSED);
      end else if (r < 12) begin
        send_contacts($urandom_range(1, 3), 1'b1, 1'b0);
        send_cmd(CMD_ABS_TOGGLE);
      end else begin
        send_contacts($urandom_range(1, 4), 1'b1, 1'b1);
      end
    end
  endtask

  // output side back pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // compare each pointer transfer with the oldest expected one
  always @(posedge clk_i) begin : check_pointer
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pointer_q.size() == 0) begin
        $error("unexpected pointer transfer: screen_x %0d, screen_y %0d",
               m_axis_tdata[15:0], m_axis_tdata[31:16]);
        err_cnt++;
      end else begin
        want = pointer_q.pop_front();
        if (m_axis_tdata[15:0] !== want[15:0]) begin
          $error("screen_x: expected %0d, actual %0d", want[15:0], m_axis_tdata[15:0]);
          err_cnt++;
        end
        if (m_axis_tdata[31:16] !== want[31:16]) begin
          $error("screen_y: expected %0d, actual %0d", want[31:16], m_axis_tdata[31:16]);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // main sequence
  initial begin
    area_cfg[REG_AREA_LEFT] = 16'(AREA_MIN_RESET);
    area_cfg[REG_AREA_TOP] = 16'(AREA_MIN_RESET);
    area_cfg[REG_AREA_RIGHT] = 16'(AREA_MAX_RESET);
    area_cfg[REG_AREA_BOTTOM] = 16'(AREA_MAX_RESET);
    cal_area = '{default: '0};
    box = '{default: '0};
    abs_mode = 1'b0;
    cal_mode = 1'b0;
    cal_area_ok = 1'b0;
    box_ok = 1'b0;
    lead_id = '0;
    first_ok = 1'b0;
    match_ok = 1'b0;
    first_id = '0;
    first_x = '0;
    first_y = '0;
    match_x = '0;
    match_y = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows on the reset area 0..4095
    // neither mode on, unused command, then absolute mode
    add_row(CMD_CONTACT, 8'd3, 1'b1, 100, 100, 1'b1, OUT_NONE, '0, '0);
    add_row(CMD_UNUSED, 8'hff, 1'b1, -1, -1, 1'b1, OUT_NONE, '0, '0);
    add_row(CMD_ABS_TOGGLE, 8'd0, 1'b0, 0, 0, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd0, 1'b1, 0, 4095, 1'b1, OUT_GIVEN, 16'd0, 16'd65520);
    // event with no tipped contact
    add_row(CMD_CONTACT, 8'd5, 1'b0, 10, 10, 1'b1, OUT_NONE, '0, '0);
    // extremes clamp, primary id moves to 255
    add_row(CMD_CONTACT, 8'd255, 1'b1, 32767, -32768, 1'b1, OUT_GIVEN, 16'd65520, 16'd0);
    add_row(CMD_CONTACT, 8'd7, 1'b1, 100, 200, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd255, 1'b1, 2048, 1024, 1'b1, OUT_GIVEN, 16'd32768, 16'd16384);
    // toggle drops a half collected event
    add_row(CMD_CONTACT, 8'd255, 1'b1, -1, 4096, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_ABS_TOGGLE, 8'd0, 1'b0, 0, 0, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd255, 1'b1, 5, 5, 1'b1, OUT_NONE, '0, '0);
    add_row(CMD_ABS_TOGGLE, 8'd0, 1'b0, 0, 0, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd9, 1'b1, 1, 1, 1'b1, OUT_GIVEN, 16'd16, 16'd16);
    // calibration with no box leaves the area alone
    add_row(CMD_CAL_TOGGLE, 8'd0, 1'b0, 0, 0, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd9, 1'b0, 0, 0, 1'b1, OUT_NONE, '0, '0);
    add_row(CMD_CAL_TOGGLE, 8'd0, 1'b0, 0, 0, 1'b0, OUT_NONE, '0, '0);
    // unused command inside an event changes nothing
    add_row(CMD_CONTACT, 8'd9, 1'b1, 4095, 0, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_UNUSED, 8'd0, 1'b1, 0, 0, 1'b1, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd1, 1'b1, 300, 300, 1'b1, OUT_GIVEN, 16'd65520, 16'd0);
    // primary id present only with tip up, so the first tipped contact wins
    add_row(CMD_CONTACT, 8'd0, 1'b1, -32768, 32767, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd9, 1'b0, 1, 1, 1'b0, OUT_NONE, '0, '0);
    add_row(CMD_CONTACT, 8'd3, 1'b1, 7, 7, 1'b1, OUT_GIVEN, 16'd0, 16'd65520);
    add_row(CMD_CONTACT, 8'd170, 1'b1, 21845, -21846, 1'b1, OUT_PREDICTED, '0, '0);
    foreach (dir_rows[i]) push_item(dir_rows[i].item, dir_rows[i].kind,
                                    dir_rows[i].ex, dir_rows[i].ey);

    // full range area, no idling
    wait_quiet(SETTLE_CYCLES);
    set_area(-32768, -32768, 32767, 32767);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    run_random(sent_cnt + PHASE_ITEMS);

    // narrow x, single row y, sender mostly idle
    wait_quiet(SETTLE_CYCLES);
    set_area(-100, 500, 99, 500);
    snd_idle_pct = 82;
    rcv_stall_pct = 0;
    run_random(sent_cnt + PHASE_ITEMS);

    // zero span x, receiver mostly stalled
    wait_quiet(SETTLE_CYCLES);
    set_area(1000, -5, 999, 5000);
    snd_idle_pct = 0;
    rcv_stall_pct = 82;
    run_random(sent_cnt + PHASE_ITEMS);

    // negative span area, then calibration boxes take over; both sides idle
    wait_quiet(SETTLE_CYCLES);
    set_area(32767, 0, -32768, 1);
    snd_idle_pct = 28;
    rcv_stall_pct = 28;
    cal_tips_ok = 1'b1;
    run_random(sent_cnt + PHASE_ITEMS);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_quiet(DRAIN_CYCLES);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
